// ----- rtl/sv39ptw_pkg.sv -----
// Shared constants for the SV39 page table walker.
`timescale 1ns / 1ps
`default_nettype none
package sv39ptw_pkg;

  localparam int POOL_PAGES = 64;
  localparam int VPN_W      = 9;
  localparam int PT_ENTRIES = 1 << VPN_W;
  localparam int PAGE_W     = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
  localparam int CNT_W      = $clog2(POOL_PAGES + 1);
  localparam int ADDR_W     = PAGE_W + VPN_W;
  localparam int DEPTH      = POOL_PAGES * PT_ENTRIES;
  localparam int PTE_W      = 64;
  localparam int PPN_W      = 44;
  localparam int VA_W       = 39;
  localparam int PA_W       = 56;
  localparam int FLAGS_W    = 10;
  localparam int OFF_W      = 12;

  localparam logic [1:0] KIND_TRANSLATE = 2'd0;
  localparam logic [1:0] KIND_MAP       = 2'd1;
  localparam logic [1:0] KIND_UNMAP     = 2'd2;
  localparam logic [1:0] KIND_NOP       = 2'd3;

endpackage
`default_nettype wire

// ----- rtl/sv39ptw_ram.sv -----
// Generic single-port synchronous RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none
module sv39ptw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic                     we,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// ----- rtl/sv39_page_table_walker_top.sv -----
// Top level of the SV39 page table walker: walk sequencer around one table RAM.
//
//  Channel   Signals                                      Direction
//  input     in_valid/in_ready, kind, vaddr,              in
//            paddr, flags
//  result    out_valid/out_ready, status, phys_out        out
//  config    cfg_write, cfg_data (pool_base_ppn)          in
//
// A full walk reads the level 2, 1 and 0 entries in turn in ST_WAIT, then registers its
// result and enters ST_DONE; each allocated page adds a pass through ST_READ. A walk that
// stops early or a no-op word finishes sooner. The single RAM port carries every table
// read and write in turn. After reset the RAM is swept to zero, one entry a cycle across
// all POOL_PAGES*512 entries (32768), and no input word is accepted until then.
// A finished result waits in the output register while the next word is accepted.
`timescale 1ns / 1ps
`default_nettype none
module sv39_page_table_walker_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [1:0]                      kind,
  input  wire logic [sv39ptw_pkg::VA_W-1:0]    vaddr,
  input  wire logic [sv39ptw_pkg::PA_W-1:0]    paddr,
  input  wire logic [sv39ptw_pkg::FLAGS_W-1:0] flags,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 status,
  output logic      [sv39ptw_pkg::PA_W-1:0]    phys_out,
  input  wire logic                            cfg_write,
  input  wire logic [sv39ptw_pkg::PPN_W-1:0]   cfg_data
);
  import sv39ptw_pkg::*;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_READ  = 5'b00100,
    ST_WAIT  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t              state;
  logic [1:0]          kind_q;
  logic [VA_W-1:0]     va_q;
  logic [PPN_W-1:0]    pa_ppn_q;
  logic [FLAGS_W-1:0]  flags_q;
  logic [1:0]          lvl;
  logic [PAGE_W-1:0]   page;
  logic [CNT_W-1:0]    nfp;
  logic [PPN_W-1:0]    base;
  logic [ADDR_W-1:0]   clr_addr;
  logic                res_status;
  logic [PA_W-1:0]     res_phys;

  logic [ADDR_W-1:0]   mem_addr;
  logic                mem_we;
  logic [PTE_W-1:0]    mem_wdata;
  logic [PTE_W-1:0]    entry;

  logic                e_valid;
  logic [PPN_W-1:0]    e_ppn;
  logic [PPN_W-1:0]    ptr_rel;
  logic                rel_ok;
  logic                pool_full;
  logic                is_map;
  logic [VPN_W-1:0]    cur_vpn;
  logic [VPN_W-1:0]    nxt_vpn;
  logic                out_load;

  sv39ptw_ram #(
    .WIDTH (PTE_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .addr  (mem_addr),
    .we    (mem_we),
    .wdata (mem_wdata),
    .rdata (entry)
  );

  assign in_ready  = (state == ST_IDLE);
  assign out_load  = (state == ST_DONE) && (!out_valid || out_ready);
  assign e_valid   = entry[0];
  assign e_ppn     = entry[PPN_W+9:10];
  assign ptr_rel   = e_ppn - base;
  assign rel_ok    = ptr_rel < PPN_W'(POOL_PAGES);
  assign pool_full = nfp >= CNT_W'(POOL_PAGES);
  assign is_map    = (kind_q == KIND_MAP);

  // Level 2 indexes with VPN2, level 1 with VPN1, level 0 with VPN0.
  always_comb begin
    unique case (lvl)
      2'd2:    begin cur_vpn = va_q[38:30]; nxt_vpn = va_q[29:21]; end
      2'd1:    begin cur_vpn = va_q[29:21]; nxt_vpn = va_q[20:12]; end
      default: begin cur_vpn = va_q[20:12]; nxt_vpn = va_q[20:12]; end
    endcase
  end

  always_comb begin
    mem_addr  = {page, cur_vpn};
    mem_we    = 1'b0;
    mem_wdata = '0;
    unique case (state)
      ST_CLEAR: begin
        mem_addr = clr_addr;
        mem_we   = 1'b1;
      end
      ST_IDLE: begin
        // The root entry is read speculatively; it is used only if a word is accepted.
        mem_addr = {PAGE_W'(0), vaddr[38:30]};
      end
      ST_WAIT: begin
        if (lvl != 2'd0) begin
          if (e_valid) begin
            mem_addr = {ptr_rel[PAGE_W-1:0], nxt_vpn};
          end else if (is_map && !pool_full) begin
            mem_we    = 1'b1;
            mem_wdata = {10'd0, base + PPN_W'(nfp), 9'd0, 1'b1};
          end
        end else if (is_map && !e_valid) begin
          mem_we    = 1'b1;
          mem_wdata = {10'd0, pa_ppn_q, flags_q | FLAGS_W'(1)};
        end else if (kind_q == KIND_UNMAP && e_valid) begin
          mem_we = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      nfp       <= CNT_W'(1);
      base      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        base <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            kind_q   <= kind;
            va_q     <= vaddr;
            pa_ppn_q <= paddr[PA_W-1:OFF_W];
            flags_q  <= flags;
            lvl      <= 2'd2;
            page     <= '0;
            if (kind == KIND_NOP) begin
              res_status <= 1'b0;
              res_phys   <= '0;
              state      <= ST_DONE;
            end else begin
              state <= ST_WAIT;
            end
          end
        end
        ST_READ: begin
          state <= ST_WAIT;
        end
        ST_WAIT: begin
          if (lvl != 2'd0) begin
            if (e_valid && rel_ok) begin
              page <= ptr_rel[PAGE_W-1:0];
              lvl  <= lvl - 2'd1;
            end else if (!e_valid && is_map && !pool_full) begin
              // New table page; its entries must still be read back.
              nfp   <= nfp + CNT_W'(1);
              page  <= PAGE_W'(nfp);
              lvl   <= lvl - 2'd1;
              state <= ST_READ;
            end else begin
              res_status <= is_map;
              res_phys   <= '0;
              state      <= ST_DONE;
            end
          end else begin
            res_status <= is_map && e_valid;
            res_phys   <= (kind_q == KIND_TRANSLATE && e_valid) ?
                          {e_ppn, va_q[OFF_W-1:0]} : '0;
            state      <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            status   <= res_status;
            phys_out <= res_phys;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_CLEAR;
      endcase
    end
  end

`ifndef SYNTH
  a_alloc_counts: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WAIT && lvl != 2'd0 && !e_valid && is_map && !pool_full)
    |=> (nfp == $past(nfp) + CNT_W'(1)))
    else $error("allocation did not advance the free page counter");

  a_fail_only_map: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && res_status) |-> (kind_q == KIND_MAP))
    else $error("failure status on a word that is not a map");

  a_phys_only_translate: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && res_phys != '0) |-> (kind_q == KIND_TRANSLATE))
    else $error("nonzero physical address on a word that is not a translate");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE || state == ST_DONE) |-> !mem_we)
    else $error("table write outside a walk or the clearing sweep");
`endif

endmodule
`default_nettype wire

// ----- tb/sv39_page_table_walker_top_test.sv -----
// Self-checking testbench for the SV39 page table walker top level.
`timescale 1ns / 1ps
module sv39_page_table_walker_top_test;
  import sv39ptw_pkg::*;

  localparam int CHOKE_CYCLES  = 300;
  localparam int PHASE_WORDS   = 120;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [1:0]         kind;
    logic [VA_W-1:0]    va;
    logic [PA_W-1:0]    pa;
    logic [FLAGS_W-1:0] flags;
  } walk_word_t;

  typedef struct packed {
    logic            status;
    logic [PA_W-1:0] phys;
  } walk_result_t;

  typedef struct packed {
    walk_word_t   word;
    logic         has_typed;
    walk_result_t typed;
  } walk_row_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         kind;
  logic [VA_W-1:0]    vaddr;
  logic [PA_W-1:0]    paddr;
  logic [FLAGS_W-1:0] flags;
  logic               out_valid;
  logic               out_ready;
  logic               status;
  logic [PA_W-1:0]    phys_out;
  logic               cfg_write;
  logic [PPN_W-1:0]   cfg_data;

  // Shadow copy of the table pool, the bump counter and the base register.
  logic [PTE_W-1:0] pt_store [DEPTH];
  int unsigned      pt_next_page;
  logic [PPN_W-1:0] pt_base;

  walk_result_t expected_results [$];
  walk_row_t    directed_rows [$];
  logic [VPN_W-1:0] hot_vpn [8];
  int  error_count;
  bit  tx_calm;
  bit  choke_req;

  sv39_page_table_walker_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .vaddr     (vaddr),
    .paddr     (paddr),
    .flags     (flags),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .phys_out  (phys_out),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  // Follows one pointer entry, allocating a table page when asked to.
  function automatic bit follow_pointer(input int unsigned page, input logic [VPN_W-1:0] vpn,
                                        input bit create, output int unsigned next_page);
    int unsigned      e;
    logic [PPN_W-1:0] rel;
    e = page * PT_ENTRIES + vpn;
    next_page = 0;
    if (!pt_store[e][0]) begin
      if (!create) return 1'b0;
      if (pt_next_page >= POOL_PAGES) return 1'b0;
      pt_store[e] = {10'b0, pt_base + PPN_W'(pt_next_page), 9'b0, 1'b1};
      pt_next_page++;
    end
    rel = pt_store[e][53:10] - pt_base;
    if (rel >= POOL_PAGES) return 1'b0;
    next_page = int'(rel);
    return 1'b1;
  endfunction

  function automatic bit leaf_slot(input logic [VA_W-1:0] va, input bit create,
                                   output int unsigned leaf);
    int unsigned p1;
    int unsigned p0;
    leaf = 0;
    if (!follow_pointer(0, va[38:30], create, p1)) return 1'b0;
    if (!follow_pointer(p1, va[29:21], create, p0)) return 1'b0;
    leaf = p0 * PT_ENTRIES + va[20:12];
    return 1'b1;
  endfunction

  function automatic walk_result_t walk_outcome(input walk_word_t w);
    walk_result_t r;
    int unsigned  leaf;
    bit           hit;
    r = '0;
    case (w.kind)
      KIND_TRANSLATE: begin
        hit = leaf_slot(w.va, 1'b0, leaf);
        if (hit && pt_store[leaf][0]) r.phys = {pt_store[leaf][53:10], w.va[11:0]};
      end
      KIND_MAP: begin
        hit = leaf_slot(w.va, 1'b1, leaf);
        if (!hit || pt_store[leaf][0]) r.status = 1'b1;
        else pt_store[leaf] = {10'b0, w.pa[55:12], w.flags | 10'b1};
      end
      KIND_UNMAP: begin
        hit = leaf_slot(w.va, 1'b0, leaf);
        if (hit && pt_store[leaf][0]) pt_store[leaf] = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic walk_word_t random_word();
    walk_word_t w;
    int         r;
    r = $urandom_range(0, 99);
    if (r < 40) w.kind = KIND_MAP;
    else if (r < 75) w.kind = KIND_TRANSLATE;
    else if (r < 95) w.kind = KIND_UNMAP;
    else w.kind = KIND_NOP;
    // Most addresses come from a few table slots so that walks hit and
    // leaves collide; the rest spread out and use up the pool.
    if ($urandom_range(0, 9) < 7)
      w.va = {hot_vpn[$urandom_range(0, 3)], hot_vpn[$urandom_range(0, 3)],
              hot_vpn[$urandom_range(0, 7)], 12'($urandom)};
    else
      w.va = VA_W'({$urandom, $urandom});
    w.pa    = PA_W'({$urandom, $urandom});
    w.flags = FLAGS_W'($urandom);
    return w;
  endfunction

  function automatic void add_row(input logic [1:0] k, input logic [VA_W-1:0] va,
                                  input logic [PA_W-1:0] pa, input logic [FLAGS_W-1:0] fl,
                                  input logic has_typed, input logic st,
                                  input logic [PA_W-1:0] ph);
    walk_row_t row;
    row.word      = '{kind: k, va: va, pa: pa, flags: fl};
    row.has_typed = has_typed;
    row.typed     = '{status: st, phys: ph};
    directed_rows.push_back(row);
  endfunction

  task automatic set_pool_base(input logic [PPN_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    pt_base = value;
  endtask

  task automatic send_word(input walk_word_t w, input logic has_typed,
                           input walk_result_t typed);
    int           gap;
    walk_result_t r;
    gap = tx_calm ? 0 : idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= w.kind;
    vaddr    <= w.va;
    paddr    <= w.pa;
    flags    <= w.flags;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = walk_outcome(w);
    expected_results.push_back(has_typed ? typed : r);
  endtask

  task automatic drain_results();
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls, calm stretches, and one long hold-off on request.
  initial begin
    int stall;
    int calm_left;
    bit calm;
    out_ready = 1'b0;
    stall     = 0;
    calm_left = 0;
    calm      = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (choke_req) begin
        out_ready <= 1'b0;
        repeat (CHOKE_CYCLES) @(posedge clk);
        choke_req = 1'b0;
      end else begin
        if (calm_left == 0) begin
          calm      = ($urandom_range(0, 2) == 0);
          calm_left = $urandom_range(20, 200);
        end
        calm_left--;
        if (stall > 0) begin
          out_ready <= 1'b0;
          stall--;
        end else begin
          out_ready <= 1'b1;
          if (!calm) stall = idle_gap();
        end
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    walk_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected word, status %0d phys_out %h", $time, status, phys_out);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, status);
          error_count++;
        end
        if (phys_out !== want.phys) begin
          $display("%0t: phys_out expected %h, got %h", $time, want.phys, phys_out);
          error_count++;
        end
      end
    end
  end

  initial begin
    logic [PPN_W-1:0] phase_base [4];
    walk_result_t     no_typed;
    rst          = 1'b1;
    in_valid     = 1'b0;
    kind         = KIND_NOP;
    vaddr        = '0;
    paddr        = '0;
    flags        = '0;
    cfg_write    = 1'b0;
    cfg_data     = '0;
    error_count  = 0;
    tx_calm      = 1'b0;
    choke_req    = 1'b0;
    no_typed     = '0;
    pt_next_page = 1;
    pt_base      = '0;
    foreach (pt_store[i]) pt_store[i] = '0;
    hot_vpn = '{9'd0, 9'd511, 9'd1, 9'd170, 9'd341, 9'd2, 9'd256, 9'd77};
    phase_base[0] = '1;
    phase_base[1] = PPN_W'({$urandom, $urandom});
    phase_base[2] = '0;
    phase_base[3] = PPN_W'(2);

    add_row(KIND_TRANSLATE, '0, '0, '0, 1'b1, 1'b0, '0);
    add_row(KIND_UNMAP, '1, '0, '0, 1'b1, 1'b0, '0);
    add_row(KIND_NOP, '1, '1, '1, 1'b1, 1'b0, '0);
    add_row(KIND_MAP, '0, '1, '0, 1'b1, 1'b0, '0);
    add_row(KIND_TRANSLATE, 39'hFFF, '0, '0, 1'b1, 1'b0, '1);
    add_row(KIND_MAP, '0, '0, '0, 1'b1, 1'b1, '0);
    add_row(KIND_MAP, '1, '0, '1, 1'b1, 1'b0, '0);
    add_row(KIND_TRANSLATE, '1, '0, '0, 1'b1, 1'b0, 56'hFFF);
    add_row(KIND_MAP, '1, 56'h1000, '0, 1'b1, 1'b1, '0);
    add_row(KIND_UNMAP, '1, '0, '0, 1'b1, 1'b0, '0);
    add_row(KIND_TRANSLATE, '1, '0, '0, 1'b1, 1'b0, '0);
    add_row(KIND_MAP, '1, 56'hA5_A5A5_A5A5_A5A5, 10'h155, 1'b0, 1'b0, '0);
    add_row(KIND_TRANSLATE, 39'h7F_FFFF_F5A5, '0, '0, 1'b0, 1'b0, '0);
    add_row(KIND_MAP, 39'h1000, 56'h12_3456_7890_1ABC, 10'h2AA, 1'b0, 1'b0, '0);
    add_row(KIND_TRANSLATE, 39'h1234, '0, '0, 1'b0, 1'b0, '0);
    add_row(KIND_NOP, 39'h1234, '0, '0, 1'b1, 1'b0, '0);
    add_row(KIND_UNMAP, 39'h1000, '0, '0, 1'b0, 1'b0, '0);
    add_row(KIND_TRANSLATE, 39'h1000, '0, '0, 1'b1, 1'b0, '0);
    add_row(KIND_MAP, 39'h00_7FE0_0000, 56'h80_0000_0000_0000, '0, 1'b0, 1'b0, '0);
    add_row(KIND_TRANSLATE, 39'h00_7FE0_0ABC, '0, '0, 1'b0, 1'b0, '0);
    add_row(KIND_UNMAP, 39'h00_7FE0_0000, '1, '1, 1'b0, 1'b0, '0);
    add_row(KIND_TRANSLATE, '0, '0, '0, 1'b0, 1'b0, '0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    set_pool_base('0);

    // The first words wait out the clearing sweep of the table RAM.
    foreach (directed_rows[i])
      send_word(directed_rows[i].word, directed_rows[i].has_typed, directed_rows[i].typed);
    in_valid <= 1'b0;
    drain_results();

    for (int p = 0; p < 4; p++) begin
      set_pool_base(phase_base[p]);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (n % 25 == 0) tx_calm = ($urandom_range(0, 3) == 0);
        // Hold the result side off while words keep coming, so the walker backs up.
        if (p == 1 && n == 10) choke_req = 1'b1;
        send_word(random_word(), 1'b0, no_typed);
      end
      in_valid <= 1'b0;
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
